[rtl/core/mstk_pkg.sv]
// Package for the Kruskal minimum spanning tree block.
// Holds the size constants and the sequencer state type; no dependencies.
`default_nettype none
package mstk_pkg;
  localparam int MaxVertices = 32;
  localparam int MaxEdges    = 256;
  localparam int WeightBits  = 16;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_KEY,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_UF_RD,
    ST_UF_EDGE,
    ST_UF_FIND,
    ST_CONN,
    ST_CONN_FIND,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_NT,
    ST_EMIT_WAIT,
    ST_CLEAR
  } state_t;
endpackage
`default_nettype wire

[rtl/core/minimum_spanning_tree_kruskal_top.sv]
// Kruskal minimum spanning tree over an edge store, a parent table and a kept-edge memory;
// depends on mstk_pkg. Edges load at one transaction per cycle while s_tready is high.
// After the last edge an insertion sort orders the store by weight, then union-find walks
// both roots of each edge, the connectivity check walks each used vertex to its root, and
// each result is held through output stalls. Every run ends with a parent table clear;
// synchronous reset starts the same clear.
`default_nettype none
module minimum_spanning_tree_kruskal_top #(
  parameter int MAX_EDGES = mstk_pkg::MaxEdges
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // src_vertex[4:0], dst_vertex[9:5], weight[25:10], zero fill [31:26]
  input  wire logic [31:0] s_tdata,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tree_src[4:0], tree_dst[9:5], tree_weight[25:10], zero fill [31:26]
  output logic [31:0]      m_tdata,
  // no_tree[0], edges_dropped[1]
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);
  import mstk_pkg::*;

  localparam int VB = $clog2(MaxVertices);
  localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CB = $clog2(MAX_EDGES + 1);
  localparam int KB = $clog2(MaxVertices - 1);
  localparam int DW = 2 * VB + WeightBits;

  // An entry is {weight, dst, src}, the same layout as the low tdata bits.
  typedef logic [DW-1:0] ent_t;

  function automatic logic signed [WeightBits-1:0] wof(input ent_t e);
    return e[DW-1 -: WeightBits];
  endfunction

  // Memories: edge store, parent table, kept edges.
  ent_t          emem [MAX_EDGES];
  logic [VB-1:0] pmem [MaxVertices];
  ent_t          kmem [MaxVertices-1];

  state_t state, state_next;
  logic [CB-1:0] count;
  logic [MaxVertices-1:0] seen;
  logic [KB-1:0] kcount, kidx;
  logic          ovf;
  logic [CB-1:0] i_idx;
  logic [EB-1:0] j_idx;
  ent_t          key, ent;
  logic [VB-1:0] cur, ra, croot;
  logic          fphase, have, tree_ok;
  logic [VB:0]   vidx;

  logic [EB-1:0] e_raddr, e_waddr;
  ent_t          e_rdata, e_wdata;
  logic          e_we;
  logic [VB-1:0] p_raddr, p_rdata, p_waddr, p_wdata;
  logic          p_we;
  ent_t          k_rdata;
  logic          k_we;

  logic [VB-1:0] in_s, in_d;
  logic          load_ok, at_root, shift_up;

  // Five-bit vertex indexes cover exactly the vertex range.
  assign in_s = s_tdata[VB-1:0];
  assign in_d = s_tdata[2*VB-1:VB];
  assign load_ok = (count < CB'(MAX_EDGES));
  assign at_root = (p_rdata == cur);
  assign shift_up = (wof(e_rdata) > wof(key));
  assign s_tready = (state == ST_LOAD);

  // Synchronous memories with registered read data.
  always_ff @(posedge clk) begin
    if (e_we) emem[e_waddr] <= e_wdata;
    e_rdata <= emem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= p_wdata;
    p_rdata <= pmem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (k_we) kmem[kcount] <= ent;
    k_rdata <= kmem[kidx];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  // Next state and memory controls.
  always_comb begin
    state_next = state;
    e_we = 1'b0;
    e_waddr = j_idx;
    e_wdata = key;
    e_raddr = i_idx[EB-1:0];
    p_we = 1'b0;
    p_waddr = cur;
    p_wdata = ra;
    p_raddr = cur;
    k_we = 1'b0;
    case (state)
      ST_LOAD: begin
        e_waddr = count[EB-1:0];
        e_wdata = s_tdata[DW-1:0];
        e_we = s_tvalid && load_ok;
        if (s_tvalid && s_tlast) state_next = ST_SORT_RD;
      end
      ST_SORT_RD: begin
        if (i_idx >= count) state_next = ST_UF_RD;
        else state_next = ST_SORT_KEY;
      end
      ST_SORT_KEY: begin
        e_raddr = j_idx - EB'(1);
        state_next = ST_SORT_CMP;
      end
      // Shift a heavier entry up one slot, or drop the key into its place.
      ST_SORT_CMP: begin
        e_we = 1'b1;
        if (shift_up) begin
          e_wdata = e_rdata;
          e_raddr = j_idx - EB'(2);
          if (j_idx == EB'(1)) state_next = ST_SORT_PUT;
        end else state_next = ST_SORT_RD;
      end
      ST_SORT_PUT: begin
        e_we = 1'b1;
        state_next = ST_SORT_RD;
      end
      ST_UF_RD: begin
        if (i_idx >= count) state_next = ST_CONN;
        else state_next = ST_UF_EDGE;
      end
      ST_UF_EDGE: begin
        p_raddr = e_rdata[VB-1:0];
        state_next = ST_UF_FIND;
      end
      // Walk to the source root, then to the destination root, then link.
      ST_UF_FIND: begin
        if (!at_root) p_raddr = p_rdata;
        else if (!fphase) p_raddr = ent[2*VB-1:VB];
        else begin
          if (cur != ra) begin
            p_we = 1'b1;
            k_we = (kcount != KB'(MaxVertices - 1));
          end
          state_next = ST_UF_RD;
        end
      end
      ST_CONN: begin
        p_raddr = vidx[VB-1:0];
        if (vidx == (VB+1)'(MaxVertices)) begin
          if (!tree_ok) state_next = ST_EMIT_NT;
          else if (kcount == '0) state_next = ST_CLEAR;
          else state_next = ST_EMIT_RD;
        end else if (seen[vidx[VB-1:0]]) state_next = ST_CONN_FIND;
      end
      ST_CONN_FIND: begin
        if (!at_root) p_raddr = p_rdata;
        else state_next = ST_CONN;
      end
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: state_next = ST_EMIT_WAIT;
      ST_EMIT_NT: state_next = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (m_tready) begin
          if (m_tlast) state_next = ST_CLEAR;
          else state_next = ST_EMIT_RD;
        end
      end
      ST_CLEAR: begin
        p_we = 1'b1;
        p_waddr = vidx[VB-1:0];
        p_wdata = vidx[VB-1:0];
        if (vidx == (VB+1)'(MaxVertices - 1)) state_next = ST_LOAD;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; seen <= '0; kcount <= '0; kidx <= '0; ovf <= 1'b0;
      i_idx <= '0; j_idx <= '0; vidx <= '0; fphase <= 1'b0; have <= 1'b0;
      tree_ok <= 1'b1; m_tvalid <= 1'b0; m_tdata <= '0; m_tuser <= '0;
      m_tlast <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (s_tvalid) begin
            if (load_ok) begin
              count <= count + CB'(1);
              seen <= seen | (MaxVertices'(1) << in_s) | (MaxVertices'(1) << in_d);
            end else ovf <= 1'b1;
          end
          i_idx <= CB'(1);
        end
        ST_SORT_RD: begin
          j_idx <= i_idx[EB-1:0];
          if (i_idx >= count) i_idx <= '0;
        end
        ST_SORT_KEY: key <= e_rdata;
        ST_SORT_CMP: begin
          if (shift_up) j_idx <= j_idx - EB'(1);
          else i_idx <= i_idx + CB'(1);
        end
        ST_SORT_PUT: i_idx <= i_idx + CB'(1);
        ST_UF_RD: fphase <= 1'b0;
        ST_UF_EDGE: begin
          ent <= e_rdata;
          cur <= e_rdata[VB-1:0];
        end
        ST_UF_FIND: begin
          if (!at_root) cur <= p_rdata;
          else if (!fphase) begin
            ra <= cur;
            cur <= ent[2*VB-1:VB];
            fphase <= 1'b1;
          end else begin
            if (cur != ra && kcount != KB'(MaxVertices - 1)) kcount <= kcount + KB'(1);
            i_idx <= i_idx + CB'(1);
          end
        end
        // Every used vertex must share the root of the first used vertex.
        ST_CONN: begin
          if (vidx == (VB+1)'(MaxVertices)) vidx <= '0;
          else if (seen[vidx[VB-1:0]]) cur <= vidx[VB-1:0];
          else vidx <= vidx + (VB+1)'(1);
        end
        ST_CONN_FIND: begin
          if (!at_root) cur <= p_rdata;
          else begin
            if (!have) begin
              croot <= cur;
              have <= 1'b1;
            end else if (cur != croot) tree_ok <= 1'b0;
            vidx <= vidx + (VB+1)'(1);
          end
        end
        ST_EMIT_LD: begin
          m_tvalid <= 1'b1;
          m_tdata <= {{(32-DW){1'b0}}, k_rdata};
          m_tuser <= {ovf, 1'b0};
          m_tlast <= (kidx + KB'(1) == kcount);
        end
        ST_EMIT_NT: begin
          m_tvalid <= 1'b1;
          m_tdata <= '0;
          m_tuser <= {ovf, 1'b1};
          m_tlast <= 1'b1;
        end
        ST_EMIT_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            kidx <= kidx + KB'(1);
          end
        end
        // Restore each parent entry and clear the run state on the final one.
        ST_CLEAR: begin
          if (vidx == (VB+1)'(MaxVertices - 1)) begin
            vidx <= '0; count <= '0; seen <= '0; kcount <= '0; kidx <= '0;
            ovf <= 1'b0; have <= 1'b0; tree_ok <= 1'b1;
          end else vidx <= vidx + (VB+1)'(1);
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/core/mstk_checker.sv]
// Port-level checks for the spanning tree block, bound to its top level.
// Depends on the top level's ports only.
`default_nettype none
module mstk_port_checks (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);
  // A no_tree result has zero edge fields and ends the run.
  a_notree: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == '0) else $error("no_tree form");
  // Results are only shown while input is held off.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input open during output");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("stall");
endmodule

bind minimum_spanning_tree_kruskal_top mstk_port_checks u_chk (.*);
`default_nettype wire

[sim/mstk_checker.sv]
// Checker for the Kruskal minimum spanning tree block: watches both streams,
// predicts the tree edges of each graph and compares them. Depends on mstk_pkg.
`default_nettype none
module mstk_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,
  input  wire logic [1:0]  m_tuser,
  input  wire logic        m_tlast,
  output int               fail_count,
  output int               pending_count
);
  import mstk_pkg::*;

  typedef struct packed {
    logic [4:0]         src;
    logic [4:0]         dst;
    logic signed [15:0] weight;
  } edge_rec_t;

  typedef struct packed {
    logic [4:0]  src;
    logic [4:0]  dst;
    logic [15:0] weight;
    logic        no_tree;
    logic        dropped;
    logic        last;
  } tree_item_t;

  edge_rec_t   graph_edges[$];
  logic        graph_overflow;
  tree_item_t  expected_tree[$];

  assign pending_count = expected_tree.size();

  function automatic logic [4:0] root_of(input logic [4:0] parent[MaxVertices],
                                         input logic [4:0] v);
    logic [4:0] r;
    int steps;
    r = v;
    steps = 0;
    while (parent[r] != r && steps < MaxVertices) begin
      r = parent[r];
      steps++;
    end
    return r;
  endfunction

  // Sort the graph, run union-find and queue the results of this run.
  task automatic predict_tree();
    edge_rec_t  sorted[$];
    edge_rec_t  kept[$];
    edge_rec_t  e;
    logic [4:0] parent[MaxVertices];
    logic [MaxVertices-1:0] used;
    logic [4:0] ra, rb, first_root;
    logic       have_root, joined;
    int j;
    tree_item_t t;
    used = '0;
    for (int v = 0; v < MaxVertices; v++) parent[v] = v[4:0];
    // Stable insertion sort by signed weight.
    foreach (graph_edges[i]) begin
      e = graph_edges[i];
      used[e.src] = 1'b1;
      used[e.dst] = 1'b1;
      j = sorted.size();
      while (j > 0 && sorted[j-1].weight > e.weight) j--;
      sorted.insert(j, e);
    end
    foreach (sorted[i]) begin
      ra = root_of(parent, sorted[i].src);
      rb = root_of(parent, sorted[i].dst);
      if (ra != rb) begin
        parent[rb] = ra;
        if (kept.size() < MaxVertices - 1) kept.insert(kept.size(), sorted[i]);
      end
    end
    have_root = 1'b0;
    joined = 1'b1;
    first_root = '0;
    for (int v = 0; v < MaxVertices; v++) begin
      if (used[v]) begin
        if (!have_root) begin
          first_root = root_of(parent, v[4:0]);
          have_root = 1'b1;
        end else if (root_of(parent, v[4:0]) != first_root) begin
          joined = 1'b0;
        end
      end
    end
    if (!joined) begin
      t = '{src: '0, dst: '0, weight: '0, no_tree: 1'b1, dropped: graph_overflow,
            last: 1'b1};
      expected_tree.insert(expected_tree.size(), t);
    end else begin
      foreach (kept[i]) begin
        t = '{src: kept[i].src, dst: kept[i].dst, weight: kept[i].weight,
              no_tree: 1'b0, dropped: graph_overflow, last: (i == kept.size() - 1)};
        expected_tree.insert(expected_tree.size(), t);
      end
    end
    graph_edges.delete();
    graph_overflow = 1'b0;
  endtask

  initial begin
    fail_count = 0;
    graph_overflow = 1'b0;
  end

  // Input side: collect edges; the last edge starts a prediction.
  always @(posedge clk) begin
    edge_rec_t rec;
    if (!rst && s_tvalid && s_tready) begin
      if (graph_edges.size() < MaxEdges) begin
        rec = '{src: s_tdata[4:0], dst: s_tdata[9:5], weight: s_tdata[25:10]};
        graph_edges.insert(graph_edges.size(), rec);
      end else
        graph_overflow = 1'b1;
      if (s_tlast) predict_tree();
    end
  end

  // Output side: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    tree_item_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{src: m_tdata[4:0], dst: m_tdata[9:5], weight: m_tdata[25:10],
              no_tree: m_tuser[0], dropped: m_tuser[1], last: m_tlast};
      if (expected_tree.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_count++;
      end else begin
        want = expected_tree.pop_front();
        if (got.src != want.src || got.dst != want.dst || got.weight != want.weight
            || got.no_tree != want.no_tree || got.dropped != want.dropped
            || got.last != want.last) begin
          $display("%0t: mismatch expected src=%0d dst=%0d w=%h nt=%b dr=%b last=%b",
                   $time, want.src, want.dst, want.weight, want.no_tree,
                   want.dropped, want.last);
          $display("%0t:          actual   src=%0d dst=%0d w=%h nt=%b dr=%b last=%b",
                   $time, got.src, got.dst, got.weight, got.no_tree,
                   got.dropped, got.last);
          fail_count++;
        end
      end
    end
  end
endmodule
`default_nettype wire

[sim/minimum_spanning_tree_kruskal_top_tb.sv]
// Testbench top for the Kruskal minimum spanning tree block: sends graphs,
// stalls the output at random and gives the verdict. Depends on mstk_checker.
`default_nettype none
module minimum_spanning_tree_kruskal_top_tb;
  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  int          fail_count;
  int          pending_count;
  int          edges_sent;

  minimum_spanning_tree_kruskal_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  mstk_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output back-pressure.
  initial begin
    m_tready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      m_tready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  // Send one edge transaction, with a random gap first.
  task automatic send_edge(input logic [4:0] src, input logic [4:0] dst,
                           input logic [15:0] weight, input logic last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, weight, dst, src};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    edges_sent++;
  endtask

  task automatic end_input();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
  endtask

  // A random graph: a random spanning tree over a vertex subset, its first edge made random when broken, plus extras.
  task automatic send_graph(input int nverts, input int nextra, input bit broken);
    logic [4:0] verts[$];
    logic [4:0] v;
    int n, k;
    bit dup;
    while (verts.size() < nverts) begin
      v = 5'($urandom_range(0, 31));
      dup = 1'b0;
      foreach (verts[m]) if (verts[m] == v) dup = 1'b1;
      if (!dup) verts.insert(verts.size(), v);
    end
    n = nverts - 1 + nextra;
    for (int i = 0; i < n; i++) begin
      if (i < nverts - 1 && !(broken && i == 0)) begin
        k = $urandom_range(0, i);
        send_edge(verts[k], verts[i+1], 16'($urandom), i == n - 1);
      end else begin
        send_edge(verts[$urandom_range(0, nverts-1)], verts[$urandom_range(0, nverts-1)],
                  ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom),
                  i == n - 1);
      end
    end
    end_input();
  endtask

  // Let the checker record the last edge, then wait for every expected result.
  task automatic wait_idle();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    edges_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single edge with extreme values, both directions.
    send_edge(5'd0, 5'd31, 16'h8000, 1'b1);
    send_edge(5'd31, 5'd0, 16'h7FFF, 1'b1);
    // Self-loop only: connected but empty tree.
    send_edge(5'd7, 5'd7, 16'h0001, 1'b1);
    // Disconnected pair of edges.
    send_edge(5'd1, 5'd2, 16'hFFFF, 1'b0);
    send_edge(5'd3, 5'd4, 16'h0000, 1'b1);
    // Triangle with equal weights, a self-loop and a pendant edge; ties keep arrival order.
    send_edge(5'd5, 5'd6, 16'h0010, 1'b0);
    send_edge(5'd6, 5'd8, 16'h0010, 1'b0);
    send_edge(5'd8, 5'd8, 16'h8000, 1'b0);
    send_edge(5'd5, 5'd8, 16'h0010, 1'b0);
    send_edge(5'd21, 5'd6, 16'hFFF0, 1'b1);
    end_input();
    wait_idle();

    // Overflow: the store fills and later edges are dropped, the last included.
    for (int i = 0; i < 260; i++)
      send_edge(5'(i % 3), 5'((i + 1) % 3), 16'($urandom), i == 259);
    end_input();
    wait_idle();

    // Random graphs, mostly connected, small sizes.
    while (edges_sent < 325) begin
      send_graph($urandom_range(1, 12), $urandom_range(0, 4), $urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) wait_idle();
    end
    // One full-size graph over every vertex.
    send_graph(32, 2, 1'b0);
    wait_idle();

    if (fail_count == 0 && pending_count == 0) begin
      $display("minimum_spanning_tree_kruskal_top test passed");
    end else begin
      $display("minimum_spanning_tree_kruskal_top test failed");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("minimum_spanning_tree_kruskal_top test failed");
    $finish;
  end
endmodule
`default_nettype wire
